// ===== hw/rtl/otbm_pkg.sv =====
// Package for the octal tree bitmap membership block.
// Holds the shared types, sizing constants and helper functions.
// No dependencies; every other file of the block uses it by scoped names.
package otbm_pkg;

  localparam int MAX_LEVELS = 8;
  localparam int LVL_W      = $clog2(MAX_LEVELS);
  localparam int CNT_W      = 4;
  localparam int FILE_W     = 24;
  localparam int LC_W       = 4;
  localparam int BYTE_W     = 8;
  localparam int DIGIT_W    = 3;

  localparam int FQ_DEPTH = 2;
  localparam int FQ_PW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);
  localparam int RQ_DEPTH = 2;
  localparam int RQ_PW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_HIT    = 2'd1,
    PH_MISS   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    REG_LEVEL_COUNT   = 2'd0,
    REG_FIRST_FILE    = 2'd1,
    REG_SECOND_ENABLE = 2'd2,
    REG_SECOND_FILE   = 2'd3
  } cfg_reg_t;

  // One queued byte with its precomputed population count.
  typedef struct packed {
    logic [BYTE_W-1:0] hits;
    logic              last;
    logic [CNT_W-1:0]  ones;
  } item_t;

  typedef struct packed {
    logic match;
    logic truncated;
  } result_t;

  function automatic logic [CNT_W-1:0] ones8(input logic [BYTE_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

  // Top tree level index, 0..MAX_LEVELS-1, from the level count register clamped to 1..MAX_LEVELS.
  function automatic logic [LVL_W-1:0] top_level(input logic [LC_W-1:0] lc);
    logic [LVL_W-1:0] t;
    if (lc == '0) begin
      t = '0;
    end else if (lc > LC_W'(MAX_LEVELS)) begin
      t = LVL_W'(MAX_LEVELS - 1);
    end else begin
      t = LVL_W'(lc - LC_W'(1));
    end
    return t;
  endfunction

endpackage

// ===== hw/rtl/otbm_front.sv =====
// Front of the membership block: takes bytes in and counts their set bits.
// Short queue towards the back end. Depends on otbm_pkg.
module otbm_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [otbm_pkg::BYTE_W-1:0]   hits_byte,
  input  logic                          last_byte,
  output logic                          full,
  input  logic                          fq_pop,
  output logic                          fq_vld,
  output otbm_pkg::item_t               fq_item
);

  otbm_pkg::item_t                  mem_r [otbm_pkg::FQ_DEPTH];
  logic [otbm_pkg::FQ_PW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [otbm_pkg::FQ_CW-1:0]       count_r, count_nxt;
  logic                             do_push;
  otbm_pkg::item_t                  in_item;

  assign full    = (count_r == otbm_pkg::FQ_CW'(otbm_pkg::FQ_DEPTH));
  assign do_push = push && !full;
  assign fq_vld  = (count_r != '0);
  assign fq_item = mem_r[rd_ptr_r];

  always_comb begin
    in_item.hits = hits_byte;
    in_item.last = last_byte;
    in_item.ones = otbm_pkg::ones8(hits_byte);
  end

  always_comb begin
    count_nxt = count_r;
    if (do_push && !fq_pop) begin
      count_nxt = count_r + otbm_pkg::FQ_CW'(1);
    end else if (!do_push && fq_pop) begin
      count_nxt = count_r - otbm_pkg::FQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + otbm_pkg::FQ_PW'(1);
      end
      if (fq_pop) begin
        rd_ptr_r <= rd_ptr_r + otbm_pkg::FQ_PW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// ===== hw/rtl/otbm_lane.sv =====
// One search lane: walks the octal digits of a file number through the tree.
// Keeps a per-level stack of pending subtree counters. Depends on otbm_pkg.
module otbm_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          restart,
  input  logic                          step,
  input  otbm_pkg::item_t               item,
  input  logic [otbm_pkg::FILE_W-1:0]   file_num,
  input  logic [otbm_pkg::LVL_W-1:0]    start_level,
  output otbm_pkg::phase_t              phase_nxt_o
);

  otbm_pkg::phase_t               phase_r, phase_nxt;
  logic [otbm_pkg::LVL_W-1:0]     path_r, path_nxt;
  logic                           skip_r, skip_nxt;
  logic [otbm_pkg::LVL_W-1:0]     slvl_r, slvl_nxt;
  logic [otbm_pkg::CNT_W-1:0]     cnt_r   [otbm_pkg::MAX_LEVELS];
  logic [otbm_pkg::CNT_W-1:0]     cnt_nxt [otbm_pkg::MAX_LEVELS];

  assign phase_nxt_o = phase_nxt;

  always_comb begin
    logic [otbm_pkg::DIGIT_W-1:0] digit;
    logic [otbm_pkg::BYTE_W-1:0]  low_mask;
    logic [otbm_pkg::CNT_W-1:0]   n_low;
    logic [otbm_pkg::LVL_W-1:0]   s_dn;
    logic [otbm_pkg::LVL_W-1:0]   s_cur;
    logic                         desc;
    logic                         found;
    logic [otbm_pkg::LVL_W-1:0]   s_found;
    phase_nxt = phase_r;
    path_nxt  = path_r;
    skip_nxt  = skip_r;
    slvl_nxt  = slvl_r;
    cnt_nxt   = cnt_r;
    digit     = '0;
    for (int j = 0; j < otbm_pkg::MAX_LEVELS; j++) begin
      if (path_r == otbm_pkg::LVL_W'(j)) begin
        digit = file_num[otbm_pkg::DIGIT_W*j +: otbm_pkg::DIGIT_W];
      end
    end
    low_mask = (otbm_pkg::BYTE_W'(1) << digit) - otbm_pkg::BYTE_W'(1);
    n_low    = otbm_pkg::ones8(item.hits & low_mask);
    s_dn     = slvl_r - otbm_pkg::LVL_W'(1);
    desc     = (slvl_r != '0) && (item.ones != '0);
    s_cur    = desc ? s_dn : slvl_r;
    found    = 1'b0;
    s_found  = '0;

    if (step && phase_r == otbm_pkg::PH_SEARCH) begin
      if (!skip_r) begin
        // On the path: drop out, finish, descend, or queue the lower siblings to skip.
        if (!item.hits[digit]) begin
          phase_nxt = otbm_pkg::PH_MISS;
        end else if (path_r == '0) begin
          phase_nxt = otbm_pkg::PH_HIT;
        end else if (n_low == '0) begin
          path_nxt = path_r - otbm_pkg::LVL_W'(1);
        end else begin
          for (int j = 0; j < otbm_pkg::MAX_LEVELS; j++) begin
            if (otbm_pkg::LVL_W'(j) == path_r - otbm_pkg::LVL_W'(1)) begin
              cnt_nxt[j] = n_low;
            end
          end
          slvl_nxt = path_r - otbm_pkg::LVL_W'(1);
          skip_nxt = 1'b1;
        end
      end else begin
        // This byte roots one pending subtree: retire it, push its children.
        for (int j = 0; j < otbm_pkg::MAX_LEVELS; j++) begin
          if (otbm_pkg::LVL_W'(j) == slvl_r && cnt_r[j] != '0) begin
            cnt_nxt[j] = cnt_r[j] - otbm_pkg::CNT_W'(1);
          end
          if (desc && otbm_pkg::LVL_W'(j) == s_dn) begin
            cnt_nxt[j] = item.ones;
          end
        end
        // Lowest level at or above s_cur, still under the path, with work left.
        for (int j = otbm_pkg::MAX_LEVELS - 1; j >= 0; j--) begin
          if (cnt_nxt[j] != '0 &&
              (otbm_pkg::LVL_W'(j) == s_cur ||
               (otbm_pkg::LVL_W'(j) > s_cur && otbm_pkg::LVL_W'(j) < path_r))) begin
            found   = 1'b1;
            s_found = otbm_pkg::LVL_W'(j);
          end
        end
        if (found) begin
          slvl_nxt = s_found;
        end else begin
          skip_nxt = 1'b0;
          path_nxt = path_r - otbm_pkg::LVL_W'(1);
          if ({1'b0, s_cur} + 4'd1 >= {1'b0, path_r}) begin
            slvl_nxt = s_cur;
          end else begin
            slvl_nxt = path_r - otbm_pkg::LVL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= otbm_pkg::PH_SEARCH;
      path_r  <= '0;
      skip_r  <= 1'b0;
      slvl_r  <= '0;
      for (int j = 0; j < otbm_pkg::MAX_LEVELS; j++) begin
        cnt_r[j] <= '0;
      end
    end else if (restart) begin
      phase_r <= otbm_pkg::PH_SEARCH;
      path_r  <= start_level;
      skip_r  <= 1'b0;
      slvl_r  <= '0;
      for (int j = 0; j < otbm_pkg::MAX_LEVELS; j++) begin
        cnt_r[j] <= '0;
      end
    end else begin
      phase_r <= phase_nxt;
      path_r  <= path_nxt;
      skip_r  <= skip_nxt;
      slvl_r  <= slvl_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/otbm_back.sv =====
// Back end of the membership block: two search lanes and the result decision.
// Depends on otbm_pkg and otbm_lane.
module otbm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr,
  input  logic                          fq_vld,
  input  otbm_pkg::item_t               fq_item,
  output logic                          fq_pop,
  input  logic                          rq_full,
  input  logic [otbm_pkg::LVL_W-1:0]    start_level,
  input  logic [otbm_pkg::FILE_W-1:0]   first_file,
  input  logic                          second_enable,
  input  logic [otbm_pkg::FILE_W-1:0]   second_file,
  output logic                          res_vld,
  output otbm_pkg::result_t             res
);

  logic             restart;
  otbm_pkg::phase_t ph0, ph1;

  // Hold a closing byte until the result queue has room.
  assign fq_pop  = fq_vld && (!fq_item.last || !rq_full);
  assign res_vld = fq_pop && fq_item.last;
  assign restart = cfg_wr || res_vld;

  otbm_lane u_lane0 (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (restart),
    .step        (fq_pop),
    .item        (fq_item),
    .file_num    (first_file),
    .start_level (start_level),
    .phase_nxt_o (ph0)
  );

  otbm_lane u_lane1 (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (restart),
    .step        (fq_pop),
    .item        (fq_item),
    .file_num    (second_file),
    .start_level (start_level),
    .phase_nxt_o (ph1)
  );

  always_comb begin
    res.match     = (ph0 == otbm_pkg::PH_HIT) &&
                    (!second_enable || ph1 == otbm_pkg::PH_HIT);
    res.truncated = (ph0 == otbm_pkg::PH_SEARCH) ||
                    (second_enable && ph1 == otbm_pkg::PH_SEARCH);
  end

endmodule

// ===== hw/rtl/octal_tree_bitmap_membership.sv =====
// Octal tree bitmap membership: top level with configuration and result queue.
// Depends on otbm_pkg, otbm_front, otbm_lane and otbm_back.
// Throughput: one byte per cycle; a closing byte waits only while the result queue is full.
// A record's result passes through the front queue and then the result queue to the output.
// Reset (rst_n low, synchronous): both queues empty, level count 1, file numbers 0,
// second file off, lanes searching at the top level.
module octal_tree_bitmap_membership (
  input  logic                          clk,
  input  logic                          rst_n,
  // byte stream of hit records
  input  logic                          push,
  output logic                          full,
  input  logic [otbm_pkg::BYTE_W-1:0]   in_hits_byte,
  input  logic                          in_last_byte,
  // one result per record
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_match,
  output logic                          out_truncated,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [otbm_pkg::FILE_W-1:0]   cfg_wdata
);

  // Configuration registers.
  logic [otbm_pkg::LC_W-1:0]   level_count_r;
  logic [otbm_pkg::LC_W-1:0]   level_count_nxt;
  logic [otbm_pkg::FILE_W-1:0] first_file_r;
  logic                        second_enable_r;
  logic [otbm_pkg::FILE_W-1:0] second_file_r;
  logic [otbm_pkg::LVL_W-1:0]  start_level;

  // Front to back queue.
  logic              fq_vld, fq_pop;
  otbm_pkg::item_t   fq_item;

  // Back end results and the result queue.
  logic                         res_vld;
  otbm_pkg::result_t            res;
  otbm_pkg::result_t            rq_mem_r [otbm_pkg::RQ_DEPTH];
  logic [otbm_pkg::RQ_PW-1:0]   rq_wr_r, rq_rd_r;
  logic [otbm_pkg::RQ_CW-1:0]   rq_cnt_r, rq_cnt_nxt;
  logic                         rq_full;
  logic                         rq_pop;
  otbm_pkg::result_t            rq_head;

  // A level count write restarts the lanes on the same edge, so take the
  // value being written rather than the one still held.
  always_comb begin
    level_count_nxt = level_count_r;
    if (cfg_we && cfg_index == otbm_pkg::REG_LEVEL_COUNT) begin
      level_count_nxt = cfg_wdata[otbm_pkg::LC_W-1:0];
    end
  end

  // Clamp the level count once, so each lane starts at the right top level.
  assign start_level = otbm_pkg::top_level(level_count_nxt);

  // Any write restarts both lanes; the user writes only while the block is idle, unchecked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r   <= otbm_pkg::LC_W'(1);
      first_file_r    <= '0;
      second_enable_r <= 1'b0;
      second_file_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        otbm_pkg::REG_LEVEL_COUNT:   level_count_r   <= cfg_wdata[otbm_pkg::LC_W-1:0];
        otbm_pkg::REG_FIRST_FILE:    first_file_r    <= cfg_wdata;
        otbm_pkg::REG_SECOND_ENABLE: second_enable_r <= cfg_wdata[0];
        otbm_pkg::REG_SECOND_FILE:   second_file_r   <= cfg_wdata;
        default:                     level_count_r   <= level_count_r;
      endcase
    end
  end

  // Front: take bytes, count their bits, queue them for the lanes.
  otbm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .hits_byte (in_hits_byte),
    .last_byte (in_last_byte),
    .full      (full),
    .fq_pop    (fq_pop),
    .fq_vld    (fq_vld),
    .fq_item   (fq_item)
  );

  // Back: both lanes advance on every byte popped from the front queue.
  otbm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr        (cfg_we),
    .fq_vld        (fq_vld),
    .fq_item       (fq_item),
    .fq_pop        (fq_pop),
    .rq_full       (rq_full),
    .start_level   (start_level),
    .first_file    (first_file_r),
    .second_enable (second_enable_r),
    .second_file   (second_file_r),
    .res_vld       (res_vld),
    .res           (res)
  );

  // Result queue: parts the lanes from a stalled consumer.
  assign rq_full       = (rq_cnt_r == otbm_pkg::RQ_CW'(otbm_pkg::RQ_DEPTH));
  assign empty         = (rq_cnt_r == '0);
  assign rq_pop        = pop && !empty;
  assign rq_head       = rq_mem_r[rq_rd_r];
  assign out_match     = rq_head.match;
  assign out_truncated = rq_head.truncated;

  always_comb begin
    rq_cnt_nxt = rq_cnt_r;
    if (res_vld && !rq_pop) begin
      rq_cnt_nxt = rq_cnt_r + otbm_pkg::RQ_CW'(1);
    end else if (!res_vld && rq_pop) begin
      rq_cnt_nxt = rq_cnt_r - otbm_pkg::RQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      if (res_vld) begin
        rq_wr_r <= rq_wr_r + otbm_pkg::RQ_PW'(1);
      end
      if (rq_pop) begin
        rq_rd_r <= rq_rd_r + otbm_pkg::RQ_PW'(1);
      end
      rq_cnt_r <= rq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      rq_mem_r[rq_wr_r] <= res;
    end
  end

  // A result is only produced when the result queue can take it.
  a_res_room : assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> !rq_full)
    else $error("result produced while result queue full");

  // The lanes only advance on a byte that is really queued.
  a_pop_valid : assert property (@(posedge clk) disable iff (!rst_n)
    fq_pop |-> fq_vld)
    else $error("front queue popped while empty");

  // After a byte is taken, the front queue is not empty on the next cycle.
  a_push_seen : assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full) |=> fq_vld)
    else $error("accepted byte not queued");

endmodule

// ===== sim/octal_tree_bitmap_membership_test.sv =====
// Self-checking testbench for octal_tree_bitmap_membership: directed table, then random records.
// Tracks both lanes of the tree walk in-line and checks every verdict in order.
// Depends on otbm_pkg and the octal_tree_bitmap_membership RTL only.
module octal_tree_bitmap_membership_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 8;     // lets an open record's bytes leave the input queue
  localparam int STALL_LIMIT  = 3000;  // cycles without any accepted request
  localparam int RANDOM_ITEMS = 1850;

  typedef enum bit {ROW_DATA, ROW_WRITE} row_kind_t;

  // One row of the directed table: either a register write or one record byte.
  // Where typed is set the verdict is written out here instead of tracked.
  typedef struct packed {
    row_kind_t                   kind;
    otbm_pkg::cfg_reg_t          reg_idx;
    logic [otbm_pkg::FILE_W-1:0] value;
    logic [otbm_pkg::BYTE_W-1:0] hits;
    logic                        last;
    logic                        typed;
    logic                        match;
    logic                        truncated;
  } step_t;

  typedef struct packed {
    logic [otbm_pkg::BYTE_W-1:0] hits;
    logic                        last;
  } rec_byte_t;

  typedef struct packed {
    logic [3:0] h;
    logic       on_a;
    logic       on_b;
  } node_t;

  localparam int N_DIRECTED = 32;
  localparam step_t DIRECTED [N_DIRECTED] = '{
    // level count 1, first file 0: the root byte is the only byte
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h01, 1'b1, 1'b1, 1'b1, 1'b0},
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'hFE, 1'b1, 1'b1, 1'b0, 1'b0},
    // miss on the first byte, the second byte must be ignored
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'hFF, 1'b1, 1'b1, 1'b0, 1'b0},
    // all high digits set but ignored: only digit 7 counts
    '{ROW_WRITE, otbm_pkg::REG_FIRST_FILE,    24'hFFFFFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h80, 1'b1, 1'b1, 1'b1, 1'b0},
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h7F, 1'b1, 1'b1, 1'b0, 1'b0},
    // level count 0 behaves as 1
    '{ROW_WRITE, otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h80, 1'b1, 1'b1, 1'b1, 1'b0},
    // two levels, file octal 12: skip the subtree of child 0, then descend
    '{ROW_WRITE, otbm_pkg::REG_LEVEL_COUNT,   24'd2,      8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, otbm_pkg::REG_FIRST_FILE,    24'o12,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h03, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h04, 1'b1, 1'b0, 1'b0, 1'b0},
    // record ends on the root while the lane still searches
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h02, 1'b1, 1'b1, 1'b0, 1'b1},
    // leave a record hanging, a register write abandons it
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h02, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, otbm_pkg::REG_FIRST_FILE,    24'd0,      8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h01, 1'b1, 1'b1, 1'b0, 1'b1},
    // level count above the maximum behaves as the maximum: eight levels deep
    '{ROW_WRITE, otbm_pkg::REG_LEVEL_COUNT,   24'd9,      8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h01, 1'b1, 1'b1, 1'b1, 1'b0},
    // second lane on, file 3: both digits needed
    '{ROW_WRITE, otbm_pkg::REG_LEVEL_COUNT,   24'd1,      8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, otbm_pkg::REG_SECOND_ENABLE, 24'd1,      8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, otbm_pkg::REG_SECOND_FILE,   24'd3,      8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h09, 1'b1, 1'b1, 1'b1, 1'b0},
    '{ROW_DATA,  otbm_pkg::REG_LEVEL_COUNT,   24'd0,      8'h01, 1'b1, 1'b1, 1'b0, 1'b0}
  };

  logic                        clk;
  logic                        rst_n;
  logic                        push;
  logic                        full;
  logic [otbm_pkg::BYTE_W-1:0] in_hits_byte;
  logic                        in_last_byte;
  logic                        empty;
  logic                        pop = 1'b0;
  logic                        out_match;
  logic                        out_truncated;
  logic                        cfg_we;
  logic [1:0]                  cfg_index;
  logic [otbm_pkg::FILE_W-1:0] cfg_wdata;

  // Shadow of the register file
  logic [otbm_pkg::LC_W-1:0]   lvl_reg;
  logic [otbm_pkg::FILE_W-1:0] first_reg;
  logic                        second_on;
  logic [otbm_pkg::FILE_W-1:0] second_reg;

  // Shadow of the two lanes: phase, current path level, skip state and pending counters
  otbm_pkg::phase_t trk_phase [2];
  int               trk_depth [2];
  bit               trk_skip [2];
  int               trk_skip_lvl [2];
  int               trk_pending [2][otbm_pkg::MAX_LEVELS];

  otbm_pkg::result_t verdicts_due[$];
  rec_byte_t         tree_bytes[$];

  int fail_count  = 0;
  int bytes_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  bit cfg_open    = 1'b0;

  // Receiver pattern state
  int ready_mode   = 0;
  int ready_left   = 0;
  int ready_period = 2;
  int ready_tick   = 0;

  octal_tree_bitmap_membership DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_hits_byte (in_hits_byte),
    .in_last_byte (in_last_byte),
    .empty        (empty),
    .pop          (pop),
    .out_match    (out_match),
    .out_truncated(out_truncated),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Lane tracking
  // ---------------------------------------------------------------------------

  // Clamp the level count register into 1..MAX_LEVELS
  function automatic int eff_levels();
    if (lvl_reg == '0) return 1;
    if (lvl_reg > otbm_pkg::MAX_LEVELS) return otbm_pkg::MAX_LEVELS;
    return int'(lvl_reg);
  endfunction

  // Restart both lanes at the top level
  function automatic void restart_lanes();
    for (int k = 0; k < 2; k++) begin
      trk_phase[k]    = otbm_pkg::PH_SEARCH;
      trk_depth[k]    = eff_levels() - 1;
      trk_skip[k]     = 1'b0;
      trk_skip_lvl[k] = 0;
      for (int s = 0; s < otbm_pkg::MAX_LEVELS; s++) trk_pending[k][s] = 0;
    end
  endfunction

  function automatic void apply_write(otbm_pkg::cfg_reg_t idx,
                                      logic [otbm_pkg::FILE_W-1:0] v);
    case (idx)
      otbm_pkg::REG_LEVEL_COUNT:   lvl_reg    = v[otbm_pkg::LC_W-1:0];
      otbm_pkg::REG_FIRST_FILE:    first_reg  = v;
      otbm_pkg::REG_SECOND_ENABLE: second_on  = v[0];
      default:                     second_reg = v;
    endcase
    // any write abandons the record in progress
    restart_lanes();
  endfunction

  // Walk one lane over one bitmap byte
  function automatic void advance_lane(int k, logic [otbm_pkg::BYTE_W-1:0] b,
                                       logic [otbm_pkg::FILE_W-1:0] file);
    int d;
    int n;
    int s;
    if (trk_phase[k] != otbm_pkg::PH_SEARCH) return;
    if (!trk_skip[k]) begin
      d = int'((file >> (3 * trk_depth[k])) & 24'd7);
      if (!b[d]) begin
        trk_phase[k] = otbm_pkg::PH_MISS;
        return;
      end
      if (trk_depth[k] == 0) begin
        trk_phase[k] = otbm_pkg::PH_HIT;
        return;
      end
      // lower-numbered siblings hold subtrees that must be stepped over first
      n = $countones(b & ((8'd1 << d) - 8'd1));
      if (n == 0) begin
        trk_depth[k]--;
      end else begin
        s = trk_depth[k] - 1;
        trk_pending[k][s] = n;
        trk_skip_lvl[k]   = s;
        trk_skip[k]       = 1'b1;
      end
      return;
    end
    // this byte roots one pending subtree of height skip level plus one
    s = trk_skip_lvl[k];
    if (trk_pending[k][s] > 0) trk_pending[k][s]--;
    if (s > 0 && b != '0) begin
      s--;
      trk_pending[k][s] = $countones(b);
    end
    while (trk_pending[k][s] == 0) begin
      if (s + 1 >= trk_depth[k]) begin
        trk_skip[k] = 1'b0;
        trk_depth[k]--;
        break;
      end
      s++;
    end
    trk_skip_lvl[k] = s;
  endfunction

  // Feed one accepted byte to both lanes; returns 1 with the verdict on a last byte
  function automatic bit track_byte(input logic [otbm_pkg::BYTE_W-1:0] h, input logic l,
                                    output otbm_pkg::result_t r);
    advance_lane(0, h, first_reg);
    advance_lane(1, h, second_reg);
    r = '0;
    if (!l) return 1'b0;
    r.match     = trk_phase[0] == otbm_pkg::PH_HIT &&
                  (!second_on || trk_phase[1] == otbm_pkg::PH_HIT);
    r.truncated = trk_phase[0] == otbm_pkg::PH_SEARCH ||
                  (second_on && trk_phase[1] == otbm_pkg::PH_SEARCH);
    restart_lanes();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Record generation
  // ---------------------------------------------------------------------------

  // Build a depth-first tree that follows both file paths most of the time.
  // Inner nodes stay sparse, leaf bytes are fully random, and off-path nodes turn empty once the byte budget runs out.
  function automatic void grow_tree(input int budget);
    node_t                       stack[$];
    node_t                       nd;
    logic [otbm_pkg::BYTE_W-1:0] b;
    int                          da;
    int                          db;
    tree_bytes.delete();
    stack.push_back(node_t'{4'(eff_levels() - 1), 1'b1, 1'b1});
    while (stack.size() != 0) begin
      nd = stack.pop_back();
      da = int'((first_reg >> (3 * nd.h)) & 24'd7);
      db = int'((second_reg >> (3 * nd.h)) & 24'd7);
      if (tree_bytes.size() >= budget) b = '0;
      else if (nd.h == 0) b = otbm_pkg::BYTE_W'($urandom);
      else b = otbm_pkg::BYTE_W'($urandom & $urandom & $urandom);
      if (nd.on_a && $urandom_range(0, 7) != 0) b[da] = 1'b1;
      if (nd.on_b && $urandom_range(0, 7) != 0) b[db] = 1'b1;
      tree_bytes.push_back(rec_byte_t'{b, 1'b0});
      // push in reverse so that child 0 comes out first
      if (nd.h != 0) begin
        for (int i = 7; i >= 0; i--) begin
          if (b[i]) begin
            stack.push_back(node_t'{nd.h - 4'd1, nd.on_a && i == da, nd.on_b && i == db});
          end
        end
      end
    end
  endfunction

  function automatic logic [otbm_pkg::FILE_W-1:0] pick_file();
    logic [otbm_pkg::FILE_W-1:0] f;
    case ($urandom_range(0, 3))
      0: f = otbm_pkg::FILE_W'($urandom);
      1: begin
        for (int i = 0; i < otbm_pkg::FILE_W / 3; i++) begin
          f[3*i +: 3] = $urandom_range(0, 1) ? 3'd7 : 3'd0;
        end
      end
      2: f = $urandom_range(0, 1) ? '1 : '0;
      default: f = otbm_pkg::FILE_W'($urandom_range(0, 511));
    endcase
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one byte and hold it until the request is taken. The sender works in
  // bursts; between bursts it may drop push for a random gap, now and then a long one.
  task automatic send_byte(input logic [otbm_pkg::BYTE_W-1:0] h, input logic l,
                           input bit typed, input otbm_pkg::result_t typed_r);
    otbm_pkg::result_t r;
    int                gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0:       gap = $urandom_range(10, 30);
        1, 2, 3: gap = 0;
        default: gap = $urandom_range(1, 4);
      endcase
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) :
                                                 $urandom_range(1, 24);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    push         <= 1'b1;
    in_hits_byte <= h;
    in_last_byte <= l;
    do @(posedge clk); while (full);
    burst_left--;
    bytes_sent++;
    if (track_byte(h, l, r)) verdicts_due.push_back(typed ? typed_r : r);
  endtask

  // Hold off until every verdict is in and the input queue has drained
  task automatic wait_idle();
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register; cfg_we stays high for back-to-back writes, caller lowers it
  task automatic write_reg(input otbm_pkg::cfg_reg_t idx,
                           input logic [otbm_pkg::FILE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    apply_write(idx, v);
  endtask

  // Random settings for the next phase, written while the block is idle
  task automatic reconfigure();
    logic [otbm_pkg::FILE_W-1:0] lc;
    bit                          wrote;
    wrote = 1'b0;
    push <= 1'b0;
    wait_idle();
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 9))
        0:       lc = 24'd0;
        1:       lc = 24'd8;
        2:       lc = otbm_pkg::FILE_W'($urandom_range(9, 15));
        3:       lc = 24'd1;
        default: lc = otbm_pkg::FILE_W'($urandom_range(1, 8));
      endcase
      write_reg(otbm_pkg::REG_LEVEL_COUNT, lc);
      wrote = 1'b1;
    end
    if ($urandom_range(0, 9) < 6) begin
      write_reg(otbm_pkg::REG_FIRST_FILE, pick_file());
      wrote = 1'b1;
    end
    if ($urandom_range(0, 9) < 5) begin
      write_reg(otbm_pkg::REG_SECOND_ENABLE, otbm_pkg::FILE_W'($urandom));
      wrote = 1'b1;
    end
    if (!wrote || $urandom_range(0, 9) < 5) begin
      write_reg(otbm_pkg::REG_SECOND_FILE,
                ($urandom_range(0, 3) == 0) ? first_reg : pick_file());
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed records; the rest cut short, padded, or plain noise
  task automatic send_record();
    int sel;
    int cut;
    grow_tree($urandom_range(4, 48));
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      // well-formed
    end else if (sel < 80) begin
      cut = $urandom_range(1, tree_bytes.size());
      while (tree_bytes.size() > cut) void'(tree_bytes.pop_back());
    end else if (sel < 88) begin
      repeat ($urandom_range(1, 4)) begin
        tree_bytes.push_back(rec_byte_t'{otbm_pkg::BYTE_W'($urandom), 1'b0});
      end
    end else begin
      tree_bytes.delete();
      repeat ($urandom_range(1, 6)) begin
        tree_bytes.push_back(rec_byte_t'{otbm_pkg::BYTE_W'($urandom),
                                         $urandom_range(0, 3) == 0});
      end
    end
    tree_bytes[tree_bytes.size() - 1].last = 1'b1;
    foreach (tree_bytes[i]) send_byte(tree_bytes[i].hits, tree_bytes[i].last, 1'b0, '0);
  endtask

  // Start a record and leave it open for the next register write to abandon
  task automatic send_open_record();
    int cut;
    grow_tree($urandom_range(4, 24));
    cut = $urandom_range(1, tree_bytes.size());
    for (int i = 0; i < cut; i++) send_byte(tree_bytes[i].hits, 1'b0, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking, receiver stalls and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    otbm_pkg::result_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict popped with no request waiting: match %0b truncated %0b",
                 out_match, out_truncated);
          fail_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_match !== want.match) begin
            $error("match: expected %0b, got %0b", want.match, out_match);
            fail_count++;
          end
          if (out_truncated !== want.truncated) begin
            $error("truncated: expected %0b, got %0b", want.truncated, out_truncated);
            fail_count++;
          end
        end
      end
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        // Receiver: change stall mode whenever the current mode runs out
        if (ready_left == 0) begin
          ready_mode   = $urandom_range(0, 3);
          ready_left   = $urandom_range(20, 300);
          ready_period = $urandom_range(2, 12);
        end
        ready_left--;
        ready_tick++;
        case (ready_mode)
          0:       pop <= 1'b1;
          1:       pop <= $urandom_range(0, 1);
          2:       pop <= (ready_tick % ready_period) < (ready_period / 2);
          default: pop <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        <= 1'b0;
    push         <= 1'b0;
    in_hits_byte <= '0;
    in_last_byte <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= otbm_pkg::REG_LEVEL_COUNT;
    cfg_wdata    <= '0;

    // register values after reset
    lvl_reg    = otbm_pkg::LC_W'(1);
    first_reg  = '0;
    second_on  = 1'b0;
    second_reg = '0;
    restart_lanes();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: writes wait for idle, consecutive writes share one we pulse
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        if (!cfg_open) begin
          push <= 1'b0;
          wait_idle();
        end
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].value);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_we  <= 1'b0;
          cfg_open = 1'b0;
        end
        send_byte(DIRECTED[i].hits, DIRECTED[i].last, DIRECTED[i].typed,
                  otbm_pkg::result_t'{DIRECTED[i].match, DIRECTED[i].truncated});
      end
    end

    // Random phases: new settings, a run of records, sometimes a record left open
    while (bytes_sent < N_DIRECTED + RANDOM_ITEMS) begin
      int phase_end;
      reconfigure();
      phase_end = bytes_sent + $urandom_range(60, 200);
      while (bytes_sent < phase_end) send_record();
      if ($urandom_range(0, 3) == 0) send_open_record();
    end

    push <= 1'b0;
    wait_idle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
